// File: src/swc_pkg.sv
// Shared types and constants for the segment write coalescer.
// Used by swc_apb_regs and segment_write_coalescer; depends on nothing else.
`default_nettype none

package swc_pkg;

	// table sizing
	localparam int FRAME_ENTRIES = 32;
	localparam int NUM_CHIPS     = 2;
	localparam int CONTINUE_BIT  = 128;

	localparam int IDX_W = $clog2(FRAME_ENTRIES);
	localparam int CNT_W = $clog2(FRAME_ENTRIES + 1);
	localparam int TOT_W = $clog2(2 * FRAME_ENTRIES + 1);

	// field widths
	localparam int ADDR_W   = 6;
	localparam int DATA_W   = 8;
	localparam int CODE_W   = 7;
	localparam int CMD_W    = 8;
	localparam int KEY_W    = 1 + ADDR_W;
	localparam int NUM_KEYS = 2 ** KEY_W;

	// register port
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_CHIP0 = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_CHIP1 = 1'b1;
	localparam logic [CODE_W-1:0] CHIP0_CODE_RST = 7'd96;
	localparam logic [CODE_W-1:0] CHIP1_CODE_RST = 7'd97;

	// table key: chip in the top bit, ram address below
	typedef logic [KEY_W-1:0] key_t;

	typedef struct packed {
		logic [CODE_W-1:0] chip0_code;
		logic [CODE_W-1:0] chip1_code;
	} sel_codes_t;

	// command byte for a write to the given chip
	function automatic logic [CMD_W-1:0] cmd_byte(input logic chip_sel,
			input sel_codes_t codes);
		logic [CODE_W-1:0] code;
		code = chip_sel ? codes.chip1_code : codes.chip0_code;
		return CMD_W'(CONTINUE_BIT) | CMD_W'(code);
	endfunction

endpackage

`default_nettype wire

// File: src/swc_apb_regs.sv
// Register port of the segment write coalescer: the two device-select codes.
// Depends on swc_pkg.
`default_nettype none

module swc_apb_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [swc_pkg::PADDR_W-1:0] paddr,
	input  wire logic [swc_pkg::PDATA_W-1:0] pwdata,
	output logic      [swc_pkg::PDATA_W-1:0] prdata,
	output logic                             pready,
	output swc_pkg::sel_codes_t              codes
);
	import swc_pkg::*;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;
	sel_codes_t           codes_q;

	// word index, byte lanes ignored
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// select-code registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.chip0_code <= CHIP0_CODE_RST;
			codes_q.chip1_code <= CHIP1_CODE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_CHIP0: codes_q.chip0_code <= pwdata[CODE_W-1:0];
				REG_CHIP1: codes_q.chip1_code <= pwdata[CODE_W-1:0];
				default:   codes_q <= codes_q;
			endcase
		end
	end

	// readback
	always_comb begin
		case (reg_idx)
			REG_CHIP0: prdata = PDATA_W'(codes_q.chip0_code);
			REG_CHIP1: prdata = PDATA_W'(codes_q.chip1_code);
			default:   prdata = '0;
		endcase
	end

	assign codes = codes_q;

endmodule

`default_nettype wire

// File: src/segment_write_coalescer.sv
// Segment write coalescer top level: key tables, merge sequencer, result register.
// Depends on swc_pkg and swc_apb_regs.
//
// Input channel (in_valid/in_stall): one request per item. operation 0 adds
// segment_bits into the frame entry of (chip, ram_address); operation 1 flushes.
// An add of a key already in the frame also passes through the merge state
// (read-modify-write of the key data memory). A full frame drops adds of new keys.
// A flush walks the previous frame's key list, then the current frame's key list;
// each entry visited passes through the read, lookup and emit states, and the emit
// step waits while the receiver stalls. The first write is loaded in an emit step.
// Output channel (out_valid/out_stall): one request per display write, in order:
// old keys first (zero data when absent from the new frame), then new keys;
// last_write marks the final write. A single output register holds a stalled
// write; the sequencer waits in its emit step until the register is free.
// in_stall is high while an add merge or a flush is in progress.
// Reset empties both frames and restores the select codes; no clearing pass is
// needed since per-key presence flags live in flip-flops.
// APB writes are expected only while the block is idle.
`default_nettype none

module segment_write_coalescer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// input requests
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        operation,
	input  wire logic                        chip,
	input  wire logic [swc_pkg::ADDR_W-1:0]  ram_address,
	input  wire logic [swc_pkg::DATA_W-1:0]  segment_bits,
	// output requests
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic      [swc_pkg::CMD_W-1:0]   command_byte,
	output logic      [swc_pkg::ADDR_W-1:0]  out_address,
	output logic      [swc_pkg::DATA_W-1:0]  out_data,
	output logic                             last_write,
	// register port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [swc_pkg::PADDR_W-1:0] paddr,
	input  wire logic [swc_pkg::PDATA_W-1:0] pwdata,
	output logic      [swc_pkg::PDATA_W-1:0] prdata,
	output logic                             pready
);
	import swc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MERGE,
		ST_READ,
		ST_LOOKUP,
		ST_EMIT,
		ST_FINISH
	} state_t;

	sel_codes_t codes;

	swc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.codes   (codes)
	);

	// memories: key lists (frame in the lower half, previous frame in the upper
	// half), per-key segment data
	key_t              key_mem [2 * FRAME_ENTRIES];
	logic [DATA_W-1:0] kd_mem  [NUM_KEYS];
	key_t              key_rd_q;
	logic [DATA_W-1:0] kd_rd_q;

	// control state
	state_t              state_q;
	logic                phase_q;
	logic [IDX_W-1:0]    idx_q;
	logic [CNT_W-1:0]    frame_cnt_q;
	logic [CNT_W-1:0]    prev_cnt_q;
	logic [CNT_W-1:0]    fresh_cnt_q;
	logic [TOT_W-1:0]    emit_cnt_q;
	logic [NUM_KEYS-1:0] in_frame_q;
	logic [NUM_KEYS-1:0] in_prev_q;
	key_t                key_s2;
	logic [DATA_W-1:0]   bits_s2;
	logic                emit_s2;
	logic                zero_s2;
	logic                out_valid_q;

	// request decode
	key_t             in_key;
	key_t             lk_key;
	logic             accept;
	logic             chip_ok;
	logic             add_acc;
	logic             add_new;
	logic             add_merge;
	logic             flush_acc;
	logic             frame_full;
	logic             idx_last;
	logic             out_free;
	logic             out_load;
	logic [TOT_W-1:0] total;
	logic [CNT_W-1:0] phase_cnt;

	assign in_key     = {chip, ram_address};
	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid && !in_stall;
	assign chip_ok    = (int'(chip) < NUM_CHIPS);
	assign add_acc    = accept && !operation && chip_ok;
	assign frame_full = (frame_cnt_q == CNT_W'(FRAME_ENTRIES));
	assign add_new    = add_acc && !in_frame_q[in_key] && !frame_full;
	assign add_merge  = add_acc && in_frame_q[in_key];
	assign flush_acc  = accept && operation;

	assign lk_key    = key_rd_q;
	assign phase_cnt = phase_q ? frame_cnt_q : prev_cnt_q;
	assign idx_last  = ((CNT_W'(idx_q) + CNT_W'(1)) == phase_cnt);
	assign total     = TOT_W'(prev_cnt_q) + TOT_W'(fresh_cnt_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == ST_EMIT) && emit_s2 && out_free;

	// key lists: adds append to the frame half, the second flush phase copies
	// frame keys into the previous half; one read per visited entry
	always_ff @(posedge clk) begin
		if (add_new)
			key_mem[{1'b0, frame_cnt_q[IDX_W-1:0]}] <= in_key;
		else if (state_q == ST_LOOKUP && phase_q)
			key_mem[{1'b1, idx_q}] <= key_rd_q;
		if (state_q == ST_READ)
			key_rd_q <= key_mem[{!phase_q, idx_q}];
	end

	// per-key segment data of the current frame
	always_ff @(posedge clk) begin
		if (add_new)
			kd_mem[in_key] <= segment_bits;
		else if (state_q == ST_MERGE)
			kd_mem[key_s2] <= kd_rd_q | bits_s2;
		if (add_merge)
			kd_rd_q <= kd_mem[in_key];
		else if (state_q == ST_LOOKUP)
			kd_rd_q <= kd_mem[lk_key];
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= 1'b0;
			idx_q        <= '0;
			frame_cnt_q  <= '0;
			prev_cnt_q   <= '0;
			fresh_cnt_q  <= '0;
			emit_cnt_q   <= '0;
			in_frame_q   <= '0;
			in_prev_q    <= '0;
			key_s2       <= '0;
			bits_s2      <= '0;
			emit_s2      <= 1'b0;
			zero_s2      <= 1'b0;
			out_valid_q  <= 1'b0;
			command_byte <= '0;
			out_address  <= '0;
			out_data     <= '0;
			last_write   <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (add_new) begin
						in_frame_q[in_key] <= 1'b1;
						frame_cnt_q        <= frame_cnt_q + CNT_W'(1);
						if (!in_prev_q[in_key])
							fresh_cnt_q <= fresh_cnt_q + CNT_W'(1);
					end else if (add_merge) begin
						key_s2  <= in_key;
						bits_s2 <= segment_bits;
						state_q <= ST_MERGE;
					end else if (flush_acc) begin
						emit_cnt_q <= '0;
						idx_q      <= '0;
						if (prev_cnt_q != '0) begin
							phase_q <= 1'b0;
							state_q <= ST_READ;
						end else if (frame_cnt_q != '0) begin
							phase_q <= 1'b1;
							state_q <= ST_READ;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_MERGE: begin
					state_q <= ST_IDLE;
				end
				ST_READ: begin
					state_q <= ST_LOOKUP;
				end
				// key is out of its list; fetch its data and presence
				ST_LOOKUP: begin
					key_s2  <= lk_key;
					emit_s2 <= !phase_q || !in_prev_q[lk_key];
					zero_s2 <= !phase_q && !in_frame_q[lk_key];
					state_q <= ST_EMIT;
				end
				// hand the write to the result register, then step on
				ST_EMIT: begin
					if (!emit_s2 || out_free) begin
						if (emit_s2) begin
							out_valid_q  <= 1'b1;
							command_byte <= cmd_byte(key_s2[KEY_W-1], codes);
							out_address  <= key_s2[ADDR_W-1:0];
							out_data     <= zero_s2 ? '0 : kd_rd_q;
							last_write   <= ((emit_cnt_q + TOT_W'(1)) == total);
							emit_cnt_q   <= emit_cnt_q + TOT_W'(1);
						end
						if (!idx_last) begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_READ;
						end else if (!phase_q && frame_cnt_q != '0) begin
							phase_q <= 1'b1;
							idx_q   <= '0;
							state_q <= ST_READ;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				// current frame becomes the previous one
				ST_FINISH: begin
					in_prev_q   <= in_frame_q;
					in_frame_q  <= '0;
					prev_cnt_q  <= frame_cnt_q;
					frame_cnt_q <= '0;
					fresh_cnt_q <= '0;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	// presence flags track the frame fill count
	a_frame_flags: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(in_frame_q) == int'(frame_cnt_q))
		else $error("frame presence flags disagree with fill count");

	// new keys are a subset of the frame
	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_cnt_q <= frame_cnt_q)
		else $error("new key count exceeds frame count");

	// a held write is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_valid_q) |-> !out_stall)
		else $error("result register overwritten while stalled");

	// every write of a flush was produced before the tables swap
	a_flush_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (emit_cnt_q == total))
		else $error("flush write count mismatch");

endmodule

`default_nettype wire
